### rtl/cfa_pkg.sv
package cfa_pkg;

	// Fixed field widths
	localparam int VALUE_W = 64;
	localparam int NUM_W   = 32;
	localparam int DEN_W   = 31;

	// Parameter defaults
	localparam int FRACTION_BITS_DEF = 32;
	localparam int TERM_BITS_DEF     = 31;

	localparam logic [DEN_W-1:0] MAX_DEN_RESET = DEN_W'(1000);

endpackage

### rtl/cfa_divider.sv
// Restoring divider, one quotient bit per cycle.
module cfa_divider #(
	parameter int WIDTH = cfa_pkg::VALUE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;   // dividend bits shift out, quotient bits shift in
	logic [WIDTH-1:0] div_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = !diff[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= dividend;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/continued_fraction_approximator.sv
// Best rational approximation of a Q31.32 value by continued fractions.
//
// Input: pulse start with value (two's complement fixed point, FRACTION_BITS
// fraction bits) while busy is low; the word is taken at that edge and busy
// rises on the next cycle. Output: done is high for exactly one cycle with
// numerator/denominator holding the last convergent whose terms fit in
// TERM_BITS and whose denominator does not exceed max_denominator. The
// receiver cannot stall; it must take the word in that cycle.
// Config: cfg_we/cfg_data write max_denominator (reset 1000); write only
// while busy is low.
//
// Step sequence: each Euclid step, the refused one included, passes
// through the divide state (go register, divider load, VALUE_W bit-serial
// steps), then one state each for the numerator multiply, the
// denominator multiply and the update. A new word can be started
// in the cycle done is high.
// Reset: asynchronous, active low; the sequencer returns to idle, any word
// in progress is dropped, and max_denominator returns to 1000.
module continued_fraction_approximator #(
	parameter int FRACTION_BITS = cfa_pkg::FRACTION_BITS_DEF,
	parameter int TERM_BITS     = cfa_pkg::TERM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [cfa_pkg::VALUE_W-1:0] value,
	output logic                        done,
	output logic signed [cfa_pkg::NUM_W-1:0]   numerator,
	output logic [cfa_pkg::DEN_W-1:0]   denominator,
	input  logic                        cfg_we,
	input  logic [cfa_pkg::DEN_W-1:0]   cfg_data
);

	localparam int VW = cfa_pkg::VALUE_W;
	localparam int TB = TERM_BITS;
	localparam int SW = 2 * TB + 1;   // width of a*c + p

	// Term limit 2^TB - 1
	localparam logic [SW-1:0] TERM_LIM = {{(TB + 1){1'b0}}, {TB{1'b1}}};
	// Initial divisor 2^FRACTION_BITS
	localparam logic [VW-1:0] Y_INIT = VW'(1) << FRACTION_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL_N,
		S_MUL_D,
		S_UPDATE
	} state_t;

	state_t state_q;

	logic [cfa_pkg::DEN_W-1:0] max_den_q;

	// Euclid operands
	logic [VW-1:0] x_q;
	logic [VW-1:0] y_q;
	logic [VW-1:0] r_q;
	logic          neg_q;
	logic          div_go_q;

	// Partial term a, split into low bits and an out-of-range flag
	logic [TB-1:0] a_lo_q;
	logic          a_big_q;

	// Convergents: n1/d1 previous, n2/d2 current
	logic [TB-1:0] n1_q, d1_q, n2_q, d2_q;
	logic [TB-1:0] n3_q;
	logic          n_ovf_q;

	logic [2*TB-1:0] prod_q;   // shared multiplier output

	logic                        done_q;
	logic [cfa_pkg::NUM_W-1:0]   num_q;
	logic [cfa_pkg::DEN_W-1:0]   den_q;

	// Divider
	logic          div_done;
	logic [VW-1:0] div_quo;
	logic [VW-1:0] div_rem;

	cfa_divider #(
		.WIDTH(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (x_q),
		.divisor  (y_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Multiplier operand: numerator pass, then denominator pass
	logic [TB-1:0]   mul_b;
	logic [2*TB-1:0] mul_p;

	assign mul_b = (state_q == S_MUL_N) ? n2_q : d2_q;
	assign mul_p = (2*TB)'(a_lo_q) * (2*TB)'(mul_b);

	// Candidate next terms; prod_q holds a*n2 in S_MUL_D and a*d2 in S_UPDATE
	logic [SW-1:0] sum_n;
	logic [SW-1:0] sum_d;
	logic          ovf_n;
	logic          ovf_d;
	logic [TB-1:0] d3;
	logic          den_over;

	assign sum_n = {1'b0, prod_q} + SW'(n1_q);
	assign sum_d = {1'b0, prod_q} + SW'(d1_q);

	// A zero current term never overflows; otherwise a or a*c+p past the limit
	assign ovf_n = (n2_q != '0) && (a_big_q || (sum_n > TERM_LIM));
	assign ovf_d = (d2_q != '0) && (a_big_q || (sum_d > TERM_LIM));

	assign d3       = sum_d[TB-1:0];
	assign den_over = cfa_pkg::DEN_W'(d3) > max_den_q;

	// Magnitude of the input word
	logic [VW-1:0] value_mag;

	assign value_mag = value[VW-1] ? (VW'(0) - value) : value;

	// Signed numerator from a magnitude and the input sign
	function automatic logic [cfa_pkg::NUM_W-1:0] signed_num(
		input logic [TB-1:0] mag,
		input logic          neg
	);
		logic [cfa_pkg::NUM_W-1:0] ext;
		ext = cfa_pkg::NUM_W'(mag);
		return neg ? (cfa_pkg::NUM_W'(0) - ext) : ext;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			max_den_q <= cfa_pkg::MAX_DEN_RESET;
			div_go_q  <= 1'b0;
			done_q    <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			r_q       <= '0;
			neg_q     <= 1'b0;
			a_lo_q    <= '0;
			a_big_q   <= 1'b0;
			n1_q      <= '0;
			d1_q      <= '0;
			n2_q      <= '0;
			d2_q      <= '0;
			n3_q      <= '0;
			n_ovf_q   <= 1'b0;
			prod_q    <= '0;
			num_q     <= '0;
			den_q     <= '0;
		end else begin
			div_go_q <= 1'b0;
			done_q   <= 1'b0;

			if (cfg_we) begin
				max_den_q <= cfg_data;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q      <= value_mag;
						y_q      <= Y_INIT;
						neg_q    <= value[VW-1];
						n1_q     <= '0;
						d1_q     <= TB'(1);
						n2_q     <= TB'(1);
						d2_q     <= '0;
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					// wait out the divider; go pulse is still in flight on entry
					if (div_done && !div_go_q) begin
						a_lo_q  <= div_quo[TB-1:0];
						a_big_q <= |(div_quo >> TB);
						r_q     <= div_rem;
						state_q <= S_MUL_N;
					end
				end
				S_MUL_N: begin
					prod_q  <= mul_p;
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					prod_q  <= mul_p;
					n3_q    <= sum_n[TB-1:0];
					n_ovf_q <= ovf_n;
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (n_ovf_q || ovf_d || den_over) begin
						// step refused: current convergent stands
						num_q   <= signed_num(n2_q, neg_q);
						den_q   <= cfa_pkg::DEN_W'(d2_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						n1_q <= n2_q;
						n2_q <= n3_q;
						d1_q <= d2_q;
						d2_q <= d3;
						if (r_q == '0) begin
							// exact: expansion ends here
							num_q   <= signed_num(n3_q, neg_q);
							den_q   <= cfa_pkg::DEN_W'(d3);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							x_q      <= y_q;
							y_q      <= r_q;
							div_go_q <= 1'b1;
							state_q  <= S_DIV;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign numerator   = num_q;
	assign denominator = den_q;

endmodule

### dv/tb_continued_fraction_approximator.sv
module tb_continued_fraction_approximator;
	timeunit 1ns;
	timeprecision 1ps;

	// Term cap and fixed-point scale, taken from the package defaults the DUT uses
	localparam logic [63:0] TERM_MAX   = (64'd1 << cfa_pkg::TERM_BITS_DEF) - 64'd1;
	localparam logic [63:0] ONE_FIXED  = 64'd1 << cfa_pkg::FRACTION_BITS_DEF;
	// Room for under a hundred terms per word, plus the longest sender gap
	localparam int          WATCHDOG_LIMIT = 40000;
	localparam int          TAIL_CYCLES    = 7000;
	localparam int          RAND_PHASES    = 7;
	localparam int          WORDS_PER_PHASE = 17;
	localparam int          N_DIRECTED     = 24;

	typedef struct packed {
		logic signed [cfa_pkg::NUM_W-1:0] num;
		logic [cfa_pkg::DEN_W-1:0]        den;
	} fraction_t;

	// One directed word: value, limit in force, and (when typed) the expected fraction
	typedef struct packed {
		logic [cfa_pkg::VALUE_W-1:0] fixed_val;
		logic [cfa_pkg::DEN_W-1:0]   cap;
		logic                        typed;
		logic [cfa_pkg::NUM_W-1:0]   num;
		logic [cfa_pkg::DEN_W-1:0]   den;
	} vector_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic signed [cfa_pkg::VALUE_W-1:0]   value;
	logic                                 done;
	logic signed [cfa_pkg::NUM_W-1:0]     numerator;
	logic [cfa_pkg::DEN_W-1:0]            denominator;
	logic                                 cfg_we;
	logic [cfa_pkg::DEN_W-1:0]            cfg_data;

	fraction_t    pending_fractions[$];
	logic [cfa_pkg::DEN_W-1:0] max_den_shadow;
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           burst_left = 0;

	// Directed words. Typed rows can be read straight off the algorithm:
	// reset limit, integer and half values, the two extremes, tiny magnitudes,
	// limit zero (1/0 or -1/0), limit one. The rest go through the predictor.
	vector_t directed_rows [N_DIRECTED] = '{
		'{64'h0000_0000_0000_0000, 31'd1000, 1'b1, 32'd0,          31'd1},
		'{64'h0000_0001_0000_0000, 31'd1000, 1'b1, 32'd1,          31'd1},
		'{64'hFFFF_FFFF_0000_0000, 31'd1000, 1'b1, 32'hFFFF_FFFF,  31'd1},
		'{64'h0000_0000_8000_0000, 31'd1000, 1'b1, 32'd1,          31'd2},
		// largest value: integer part exactly at the term cap
		'{64'h7FFF_FFFF_FFFF_FFFF, 31'd1000, 1'b1, 32'h7FFF_FFFF,  31'd1},
		// most negative: magnitude 2^63, integer part over the cap on the first term
		'{64'h8000_0000_0000_0000, 31'd1000, 1'b1, 32'hFFFF_FFFF,  31'd0},
		// minus one LSB: result 0/1, negated zero stays zero
		'{64'hFFFF_FFFF_FFFF_FFFF, 31'd1000, 1'b1, 32'd0,          31'd1},
		'{64'h0000_0000_0000_0001, 31'd1000, 1'b1, 32'd0,          31'd1},
		'{64'h0000_0003_243F_6A88, 31'd1000, 1'b0, 32'd0,          31'd0},
		'{64'hFFFF_FFFC_DBC0_9578, 31'd1000, 1'b0, 32'd0,          31'd0},
		'{64'h0000_0001_9E37_79B9, 31'd1000, 1'b0, 32'd0,          31'd0},
		// limit below one: first term refused
		'{64'h0000_0001_0000_0000, 31'd0,    1'b1, 32'd1,          31'd0},
		'{64'hFFFF_FFFC_DBC0_9578, 31'd0,    1'b1, 32'hFFFF_FFFF,  31'd0},
		'{64'h0000_0000_0000_0000, 31'd0,    1'b1, 32'd1,          31'd0},
		'{64'h0000_0003_243F_6A88, 31'd1,    1'b1, 32'd3,          31'd1},
		'{64'h0000_0000_8000_0000, 31'd1,    1'b0, 32'd0,          31'd0},
		// limit at full range: term cap bounds the denominator instead
		'{64'h0000_0003_243F_6A88, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		'{64'h0000_0000_0000_0001, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		'{64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		'{64'h5555_5555_5555_5555, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		// golden ratio: all-ones terms, longest run of convergents
		'{64'h0000_0001_9E37_79B9, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		'{64'h0000_0000_FFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0},
		'{64'hFFFF_FFFF_0000_0001, 31'h7FFF_FFFF, 1'b0, 32'd0,     31'd0}
	};

	continued_fraction_approximator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.done        (done),
		.numerator   (numerator),
		.denominator (denominator),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// True when term*c + p would pass the term cap; a zero c never overflows
	function automatic bit term_too_big(input logic [63:0] term, input logic [63:0] c,
			input logic [63:0] p);
		if (c == 64'd0)
			return 1'b0;
		if (term > TERM_MAX)
			return 1'b1;
		return (term * c + p) > TERM_MAX;
	endfunction

	// Exact Euclid on |value| against 2^FRACTION_BITS, keeping the last convergent
	// whose numerator and denominator fit the term cap and whose denominator fits the limit
	function automatic fraction_t best_convergent(input logic [63:0] fixed_val,
			input logic [cfa_pkg::DEN_W-1:0] den_cap);
		logic [63:0] x, y, term, rem;
		logic [63:0] num_prev, num_cur, num_next, den_prev, den_cur, den_next;
		logic        neg;
		bit          running;
		fraction_t   f;
		neg      = fixed_val[63];
		x        = neg ? (64'd0 - fixed_val) : fixed_val;
		y        = ONE_FIXED;
		num_prev = 64'd0;
		den_prev = 64'd1;
		num_cur  = 64'd1;
		den_cur  = 64'd0;
		running  = 1'b1;
		while (running) begin
			term = x / y;
			rem  = x % y;
			if (term_too_big(term, num_cur, num_prev) || term_too_big(term, den_cur, den_prev)) begin
				running = 1'b0;
			end else begin
				den_next = (den_cur == 64'd0) ? den_prev : term * den_cur + den_prev;
				if (den_next > {33'd0, den_cap}) begin
					running = 1'b0;
				end else begin
					num_next = (num_cur == 64'd0) ? num_prev : term * num_cur + num_prev;
					num_prev = num_cur;
					num_cur  = num_next;
					den_prev = den_cur;
					den_cur  = den_next;
					x        = y;
					y        = rem;
					if (y == 64'd0)
						running = 1'b0;
				end
			end
		end
		num_next = neg ? (64'd0 - num_cur) : num_cur;
		f.num    = num_next[cfa_pkg::NUM_W-1:0];
		f.den    = den_cur[cfa_pkg::DEN_W-1:0];
		return f;
	endfunction

	// Drop start and hold off until every outstanding fraction has come back
	task automatic drain();
		start <= 1'b0;
		while (pending_fractions.size() != 0)
			@(posedge clk);
	endtask

	// Limit may only change while the block is idle
	task automatic set_limit(input logic [cfa_pkg::DEN_W-1:0] cap);
		drain();
		cfg_data <= cap;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we         <= 1'b0;
		max_den_shadow  = cap;
		burst_left      = 0;
	endtask

	// Present one word (after any burst gap) and record its expected fraction on accept
	task automatic send_value(input logic [63:0] v, input logic [cfa_pkg::DEN_W-1:0] cap,
			input bit typed, input fraction_t typed_want);
		int gap;
		if (cap != max_den_shadow)
			set_limit(cap);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1, 2: gap = $urandom_range(1, 8);
				default: gap = $urandom_range(9, 400);
			endcase
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_fractions.push_back(typed ? typed_want : best_convergent(v, max_den_shadow));
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			// small integer part, random fraction: long expansions
			1: v = {$urandom_range(0, 40), $urandom};
			// exact rational p/q: expansion terminates on a zero remainder
			2: v = ({32'd0, 32'($urandom_range(0, 5000))} << cfa_pkg::FRACTION_BITS_DEF)
				/ 64'($urandom_range(1, 5000));
			// tiny magnitude
			3: v = {32'd0, $urandom} >> $urandom_range(0, 31);
			// integer part at or just below the term cap
			4: v = {32'($urandom_range(32'h7FFF_FFFC, 32'h7FFF_FFFF)), $urandom};
			default: v = {$urandom, $urandom};
		endcase
		if ($urandom_range(0, 1))
			v = 64'd0 - v;
		return v;
	endfunction

	function automatic logic [cfa_pkg::DEN_W-1:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return cfa_pkg::DEN_W'($urandom_range(1, 16));
			1: return cfa_pkg::DEN_W'($urandom_range(17, 100000));
			2: return cfa_pkg::DEN_W'($urandom);
			3: return {cfa_pkg::DEN_W{1'b1}};
			default: return cfa_pkg::DEN_W'($urandom_range(0, 3));
		endcase
	endfunction

	// Result checker: done marks one word, taken at the edge that ends its cycle
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && done) begin
			if (pending_fractions.size() == 0) begin
				$display("%0t unexpected word: numerator %0d denominator %0d",
					$time, numerator, denominator);
				mismatch_count++;
			end else begin
				want = pending_fractions.pop_front();
				if (numerator !== want.num) begin
					$display("%0t numerator mismatch: expected %0d got %0d",
						$time, want.num, numerator);
					mismatch_count++;
				end
				if (denominator !== want.den) begin
					$display("%0t denominator mismatch: expected %0d got %0d",
						$time, want.den, denominator);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: cycles with neither an accepted input nor a result
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no progress, %0d words outstanding",
				$time, pending_fractions.size());
			$display("tb_continued_fraction_approximator NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		value          = '0;
		cfg_we         = 1'b0;
		cfg_data       = '0;
		max_den_shadow = cfa_pkg::MAX_DEN_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part; the first rows run on the reset limit with no write
		foreach (directed_rows[i])
			send_value(directed_rows[i].fixed_val, directed_rows[i].cap,
				directed_rows[i].typed, '{num: directed_rows[i].num, den: directed_rows[i].den});

		// Random phases, each under its own limit
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			logic [cfa_pkg::DEN_W-1:0] cap;
			cap = pick_limit();
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				// now and then let the pipe run dry mid-phase
				if ($urandom_range(0, 15) == 0)
					drain();
				send_value(pick_value(), cap, 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_fractions.size() == 0)
			$display("tb_continued_fraction_approximator OK");
		else
			$display("tb_continued_fraction_approximator NOT OK");
		$finish;
	end

endmodule

### sim.f
rtl/cfa_pkg.sv
rtl/cfa_divider.sv
rtl/continued_fraction_approximator.sv
dv/tb_continued_fraction_approximator.sv
